### sv/gpt_pkg.sv
package gpt_pkg;

  typedef enum logic [2:0] {
    OP_PORT_READ     = 3'd0,
    OP_PORT_WRITE    = 3'd1,
    OP_AXIS_UPDATE   = 3'd2,
    OP_BUTTON_PRESS  = 3'd3,
    OP_BUTTON_RELEASE= 3'd4,
    OP_FRAME_MARK    = 3'd5
  } gpt_op_t;

  typedef enum logic [1:0] {
    SPK_NONE  = 2'd0,
    SPK_START = 2'd1,
    SPK_STOP  = 2'd2
  } gpt_spk_event_t;

  localparam logic [15:0] PORT_TONE    = 16'h0042;
  localparam logic [15:0] PORT_SPEAKER = 16'h0061;
  localparam logic [15:0] PORT_GAME    = 16'h0201;
  localparam logic [15:0] PORT_STATUS  = 16'h03DA;

  localparam logic [7:0] GAME_IDLE_BITS = 8'hF0;
  localparam logic [7:0] STATUS_FRAME   = 8'h08;
  localparam logic [7:0] LOAD_RESET     = 8'hFF;

  // axis scaling: load = (v + 127) * 48 / 254 + 3 = (v + 127) * 24 / 127 + 3
  localparam logic [7:0]  AXIS_MIN    = 8'd3;
  localparam logic [12:0] AXIS_DIV    = 13'd127;
  localparam logic [7:0]  AXIS_OFFSET = 8'd127;

  typedef struct packed {
    logic [2:0]        operation;
    logic [15:0]       port_address;
    logic [7:0]        write_data;
    logic [1:0]        axis_index;
    logic signed [7:0] axis_value;
    logic [2:0]        button_index;
  } gpt_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [1:0]  speaker_event;
    logic [15:0] speaker_divisor;
    logic [1:0]  axes_timing;
  } gpt_result_t;

endpackage

### sv/gpt_axis_scale.sv
module gpt_axis_scale
  import gpt_pkg::*;
(
  input  logic signed [7:0] axis_value,
  output logic [7:0]        load_value
);

  logic signed [7:0] sat;
  logic [8:0]        sum;
  logic [7:0]        offs;
  logic [12:0]       prod;
  logic [19:0]       recip;
  logic [5:0]        q0;
  logic [12:0]       q0_times_div;
  logic [12:0]       rem;
  logic [5:0]        quot;

  always_comb begin
    sat = (axis_value == -8'sd128) ? -8'sd127 : axis_value;
    sum = {sat[7], sat} + {1'b0, AXIS_OFFSET};
    offs = sum[7:0];
    // times 24 as two shifted copies
    prod = {1'b0, offs, 4'b0000} + {2'b00, offs, 3'b000};
    // divide by 127 through 129 / 2^14, at most one short
    recip = {7'd0, prod} * 20'd129;
    q0 = recip[19:14];
    q0_times_div = {q0, 7'd0} - {7'd0, q0};
    rem = prod - q0_times_div;
    quot = (rem >= AXIS_DIV) ? q0 + 6'd1 : q0;
    load_value = {2'b00, quot} + AXIS_MIN;
  end

endmodule

### sv/gpt_regs.sv
module gpt_regs
  import gpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        fire,
  input  gpt_item_t   item,
  output gpt_result_t result
);

  logic        joystick_present;
  logic [7:0]  game_port_bits, game_port_bits_next;
  logic [7:0]  x_timer, x_timer_next;
  logic [7:0]  y_timer, y_timer_next;
  logic [7:0]  x_load_value, x_load_value_next;
  logic [7:0]  y_load_value, y_load_value_next;
  logic [7:0]  display_status, display_status_next;
  logic [15:0] tone_divisor, tone_divisor_next;
  logic        high_byte_next, high_byte_next_next;
  logic [7:0]  speaker_control, speaker_control_next;
  logic [7:0]  scaled;
  logic [7:0]  button_mask;

  gpt_axis_scale u_scale (
    .axis_value (item.axis_value),
    .load_value (scaled)
  );

  always_comb begin
    game_port_bits_next  = game_port_bits;
    x_timer_next         = x_timer;
    y_timer_next         = y_timer;
    x_load_value_next    = x_load_value;
    y_load_value_next    = y_load_value;
    display_status_next  = display_status;
    tone_divisor_next    = tone_divisor;
    high_byte_next_next  = high_byte_next;
    speaker_control_next = speaker_control;
    result               = '0;
    button_mask          = 8'd0;
    button_mask[{1'b0, item.button_index[0]} + 3'd4] = 1'b1;

    unique case (item.operation)
      OP_PORT_READ: begin
        if (item.port_address == PORT_SPEAKER) begin
          result.read_data = speaker_control;
        end else if (item.port_address == PORT_GAME) begin
          if (!joystick_present) begin
            result.read_data = GAME_IDLE_BITS;
          end else begin
            game_port_bits_next = {game_port_bits[7:2], y_timer != 8'd0, x_timer != 8'd0};
            if (x_timer != 8'd0) x_timer_next = x_timer - 8'd1;
            if (y_timer != 8'd0) y_timer_next = y_timer - 8'd1;
            result.read_data = game_port_bits_next;
          end
        end else if (item.port_address == PORT_STATUS) begin
          result.read_data = display_status;
          display_status_next = (display_status & ~STATUS_FRAME) ^ 8'h01;
        end
      end
      OP_PORT_WRITE: begin
        if (item.port_address == PORT_TONE) begin
          if (high_byte_next) tone_divisor_next = {item.write_data, tone_divisor[7:0]};
          else                tone_divisor_next = {tone_divisor[15:8], item.write_data};
          high_byte_next_next = ~high_byte_next;
          if (high_byte_next && speaker_control[1:0] == 2'b11) begin
            result.speaker_event   = SPK_START;
            result.speaker_divisor = tone_divisor_next;
          end
        end else if (item.port_address == PORT_SPEAKER) begin
          speaker_control_next = item.write_data;
          if (item.write_data[1:0] != 2'b11) result.speaker_event = SPK_STOP;
        end else if (item.port_address == PORT_GAME) begin
          x_timer_next = x_load_value;
          y_timer_next = y_load_value;
        end
      end
      OP_AXIS_UPDATE: begin
        if (item.axis_index == 2'd0)      x_load_value_next = scaled;
        else if (item.axis_index == 2'd1) y_load_value_next = scaled;
      end
      OP_BUTTON_PRESS: begin
        if (item.button_index < 3'd2) game_port_bits_next = game_port_bits & ~button_mask;
      end
      OP_BUTTON_RELEASE: begin
        if (item.button_index < 3'd2) game_port_bits_next = game_port_bits | button_mask;
      end
      OP_FRAME_MARK: begin
        display_status_next = display_status | STATUS_FRAME;
      end
      default: begin
      end
    endcase

    result.axes_timing = {1'b0, x_timer_next != 8'd0} + {1'b0, y_timer_next != 8'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      joystick_present <= 1'b1;
      game_port_bits   <= GAME_IDLE_BITS;
      x_timer          <= 8'd0;
      y_timer          <= 8'd0;
      x_load_value     <= LOAD_RESET;
      y_load_value     <= LOAD_RESET;
      display_status   <= 8'd0;
      tone_divisor     <= 16'd0;
      high_byte_next   <= 1'b0;
      speaker_control  <= 8'd0;
    end else begin
      if (cfg_wr_en) joystick_present <= cfg_wr_data;
      if (fire) begin
        game_port_bits  <= game_port_bits_next;
        x_timer         <= x_timer_next;
        y_timer         <= y_timer_next;
        x_load_value    <= x_load_value_next;
        y_load_value    <= y_load_value_next;
        display_status  <= display_status_next;
        tone_divisor    <= tone_divisor_next;
        high_byte_next  <= high_byte_next_next;
        speaker_control <= speaker_control_next;
      end
    end
  end

endmodule

### sv/pc_gameport_timer_ports_unit.sv
// game port, display status and timer channel 2 / speaker port block
// an accepted input word passes the input register, then the result register, to its result word on the m side
// throughput: one word per cycle; the input register and the result register
//   each move on whenever the stage after them is free or draining
// reset (rst, synchronous): both stages empty, port state back to power-up values,
//   joystick_present set
module pc_gameport_timer_ports_unit
  import gpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration: joystick_present
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  // input words
  input  logic        s_tvalid,
  output logic        s_tready,
  // [15:0] port_address, [23:16] write_data, [25:24] axis_index,
  // [33:26] axis_value, [36:34] button_index, [39:37] zero
  input  logic [39:0] s_tdata,
  // [2:0] operation
  input  logic [2:0]  s_tuser,
  // result words
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] read_data, [23:8] speaker_divisor, [25:24] axes_timing, [31:26] zero
  output logic [31:0] m_tdata,
  // [1:0] speaker_event
  output logic [1:0]  m_tuser
);

  // input register
  logic        st_valid;
  gpt_item_t   st_item;
  // result register
  logic        out_valid;
  gpt_result_t out_result;

  gpt_result_t step_result;
  logic        advance;

  // the staged word moves on (and commits its state change) when the
  // result register is empty or its word is being taken this cycle
  assign advance  = st_valid && (!out_valid || m_tready);
  assign s_tready = !st_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (s_tready) begin
      st_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      st_item.operation    <= s_tuser;
      st_item.port_address <= s_tdata[15:0];
      st_item.write_data   <= s_tdata[23:16];
      st_item.axis_index   <= s_tdata[25:24];
      st_item.axis_value   <= s_tdata[33:26];
      st_item.button_index <= s_tdata[36:34];
    end
  end

  // port state and per-word decode
  gpt_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (advance),
    .item        (st_item),
    .result      (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      out_valid <= st_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_result.axes_timing, out_result.speaker_divisor,
                     out_result.read_data};
  assign m_tuser  = out_result.speaker_event;

endmodule

### test/pc_gameport_timer_ports_unit_test.sv
`timescale 1ns / 1ps

module pc_gameport_timer_ports_unit_test;
  import gpt_pkg::*;

  // opcodes outside the defined set, the block must ignore them
  localparam logic [2:0] OP_RESERVED_LO = 3'd6;
  localparam logic [2:0] OP_RESERVED_HI = 3'd7;
  // a write here is a timer mode write that the block does not decode
  localparam logic [15:0] PORT_TIMER_MODE = 16'h0043;
  localparam logic [15:0] PORT_NOWHERE    = 16'hFFFF;

  // axis scaling: load = (pos + 127) * 48 / 254 + 3
  localparam int AXIS_SPAN  = 48;
  localparam int AXIS_RANGE = 254;

  localparam int QUIET_LIMIT    = 5000;
  localparam int HOLD_OFF_LEN   = 300;
  localparam int PHASE_WORDS    = 170;
  localparam int DIRECTED_WORDS = 25;

  // ---------------------------------------------------------------------------
  // clock, reset, block ports
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // [15:0] port_address, [23:16] write_data, [25:24] axis_index,
  // [33:26] axis_value, [36:34] button_index, [39:37] zero
  logic [39:0] s_tdata = '0;
  // [2:0] operation
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [7:0] read_data, [23:8] speaker_divisor, [25:24] axes_timing, [31:26] zero
  logic [31:0] m_tdata;
  // [1:0] speaker_event
  logic [1:0]  m_tuser;

  always #6 clk = ~clk;

  pc_gameport_timer_ports_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

  // ---------------------------------------------------------------------------
  // directed words; where pinned is set the result is typed in by hand,
  // otherwise the port model below supplies it
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] port;
    logic [7:0]  wdata;
    logic [1:0]  axis;
    logic [7:0]  pos;
    logic [2:0]  button;
    logic        pinned;
    gpt_result_t want;
  } stim_row_t;

  typedef struct {
    logic        pinned;
    gpt_result_t want;
  } pin_note_t;

  stim_row_t directed_rows [DIRECTED_WORDS] = '{
    // idle game port after reset: no counters running, buttons up
    '{OP_PORT_READ, PORT_GAME, 8'h00, 2'd0, 8'h00, 3'd0, 1'b1,
      '{8'hF0, SPK_NONE, 16'h0000, 2'd0}},
    // status reads back old value, then toggles bit 0
    '{OP_PORT_READ, PORT_STATUS, 8'h00, 2'd0, 8'h00, 3'd0, 1'b1,
      '{8'h00, SPK_NONE, 16'h0000, 2'd0}},
    '{OP_FRAME_MARK, 16'h0000, 8'h00, 2'd0, 8'h00, 3'd0, 1'b1,
      '{8'h00, SPK_NONE, 16'h0000, 2'd0}},
    '{OP_PORT_READ, PORT_STATUS, 8'h00, 2'd0, 8'h00, 3'd0, 1'b1,
      '{8'h09, SPK_NONE, 16'h0000, 2'd0}},
    // unknown port reads zero
    '{OP_PORT_READ, PORT_NOWHERE, 8'hFF, 2'd3, 8'hFF, 3'd7, 1'b1,
      '{8'h00, SPK_NONE, 16'h0000, 2'd0}},
    '{OP_BUTTON_PRESS, 16'h0000, 8'h00, 2'd0, 8'h00, 3'd0, 1'b1,
      '{8'h00, SPK_NONE, 16'h0000, 2'd0}},
    '{OP_BUTTON_PRESS, 16'h0000, 8'h00, 2'd0, 8'h00, 3'd1, 1'b1,
      '{8'h00, SPK_NONE, 16'h0000, 2'd0}},
    // button beyond 1 has no effect
    '{OP_BUTTON_PRESS, 16'h0000, 8'h00, 2'd0, 8'h00, 3'd7, 1'b1,
      '{8'h00, SPK_NONE, 16'h0000, 2'd0}},
    // axis extremes: -127 gives 3, +127 gives 51
    '{OP_AXIS_UPDATE, 16'h0000, 8'h00, 2'd0, 8'h81, 3'd0, 1'b1,
      '{8'h00, SPK_NONE, 16'h0000, 2'd0}},
    '{OP_AXIS_UPDATE, 16'h0000, 8'h00, 2'd1, 8'h7F, 3'd0, 1'b1,
      '{8'h00, SPK_NONE, 16'h0000, 2'd0}},
    // axis index 3 ignored
    '{OP_AXIS_UPDATE, 16'h0000, 8'h00, 2'd3, 8'h00, 3'd0, 1'b1,
      '{8'h00, SPK_NONE, 16'h0000, 2'd0}},
    // -128 saturates to -127
    '{OP_AXIS_UPDATE, 16'h0000, 8'h00, 2'd0, 8'h80, 3'd0, 1'b1,
      '{8'h00, SPK_NONE, 16'h0000, 2'd0}},
    // game port write starts both counters (x = 3, y = 51)
    '{OP_PORT_WRITE, PORT_GAME, 8'hFF, 2'd0, 8'h00, 3'd0, 1'b1,
      '{8'h00, SPK_NONE, 16'h0000, 2'd2}},
    '{OP_PORT_READ, PORT_GAME, 8'h00, 2'd0, 8'h00, 3'd0, 1'b1,
      '{8'hC3, SPK_NONE, 16'h0000, 2'd2}},
    '{OP_BUTTON_RELEASE, 16'h0000, 8'h00, 2'd0, 8'h00, 3'd0, 1'b0, '0},
    // speaker gate and data on, no stop reported
    '{OP_PORT_WRITE, PORT_SPEAKER, 8'h03, 2'd0, 8'h00, 3'd0, 1'b1,
      '{8'h00, SPK_NONE, 16'h0000, 2'd2}},
    '{OP_PORT_WRITE, PORT_TONE, 8'h34, 2'd0, 8'h00, 3'd0, 1'b0, '0},
    '{OP_PORT_WRITE, PORT_TONE, 8'h12, 2'd0, 8'h00, 3'd0, 1'b1,
      '{8'h00, SPK_START, 16'h1234, 2'd2}},
    // a zero divisor still starts a tone, reported raw
    '{OP_PORT_WRITE, PORT_TONE, 8'h00, 2'd0, 8'h00, 3'd0, 1'b0, '0},
    '{OP_PORT_WRITE, PORT_TONE, 8'h00, 2'd0, 8'h00, 3'd0, 1'b1,
      '{8'h00, SPK_START, 16'h0000, 2'd2}},
    '{OP_PORT_WRITE, PORT_SPEAKER, 8'hFC, 2'd0, 8'h00, 3'd0, 1'b1,
      '{8'h00, SPK_STOP, 16'h0000, 2'd2}},
    // timer mode port write is dropped
    '{OP_PORT_WRITE, PORT_TIMER_MODE, 8'hFF, 2'd0, 8'h00, 3'd0, 1'b1,
      '{8'h00, SPK_NONE, 16'h0000, 2'd2}},
    '{OP_RESERVED_LO, PORT_SPEAKER, 8'hFF, 2'd0, 8'h00, 3'd0, 1'b1,
      '{8'h00, SPK_NONE, 16'h0000, 2'd2}},
    '{OP_RESERVED_HI, PORT_GAME, 8'hFF, 2'd1, 8'h7F, 3'd1, 1'b1,
      '{8'h00, SPK_NONE, 16'h0000, 2'd2}},
    '{OP_PORT_READ, PORT_SPEAKER, 8'h00, 2'd0, 8'h00, 3'd0, 1'b1,
      '{8'hFC, SPK_NONE, 16'h0000, 2'd2}}
  };

  // ---------------------------------------------------------------------------
  // port model: shadow copy of the block's state
  // ---------------------------------------------------------------------------
  logic        joy_present;
  logic [7:0]  gp_bits;
  logic [7:0]  x_count;
  logic [7:0]  y_count;
  logic [7:0]  x_load;
  logic [7:0]  y_load;
  logic [7:0]  status_reg;
  logic [15:0] tone_div;
  logic        tone_high;
  logic [7:0]  spk_ctrl;

  gpt_result_t port_result_q [$];
  pin_note_t   pin_q [$];
  int          errors = 0;

  function automatic void reset_port_model();
    joy_present = 1'b1;
    gp_bits     = GAME_IDLE_BITS;
    x_count     = '0;
    y_count     = '0;
    x_load      = LOAD_RESET;
    y_load      = LOAD_RESET;
    status_reg  = '0;
    tone_div    = '0;
    tone_high   = 1'b0;
    spk_ctrl    = '0;
  endfunction

  function automatic logic [7:0] axis_to_load(logic signed [7:0] pos);
    int v;
    v = pos;
    if (v < -127) v = -127;
    return 8'((v + 127) * AXIS_SPAN / AXIS_RANGE + int'(AXIS_MIN));
  endfunction

  function automatic gpt_result_t apply_port_event(gpt_item_t w);
    gpt_result_t r;
    r = '0;
    case (w.operation)
      OP_PORT_READ: begin
        if (w.port_address == PORT_SPEAKER) begin
          r.read_data = spk_ctrl;
        end else if (w.port_address == PORT_GAME) begin
          if (!joy_present) begin
            r.read_data = GAME_IDLE_BITS;
          end else begin
            // keep the button bits, rebuild the running-counter bits
            gp_bits = gp_bits & GAME_IDLE_BITS;
            if (x_count != 0) begin
              x_count--;
              gp_bits[0] = 1'b1;
            end
            if (y_count != 0) begin
              y_count--;
              gp_bits[1] = 1'b1;
            end
            r.read_data = gp_bits;
          end
        end else if (w.port_address == PORT_STATUS) begin
          r.read_data = status_reg;
          status_reg  = (status_reg & ~STATUS_FRAME) ^ 8'h01;
        end
      end
      OP_PORT_WRITE: begin
        if (w.port_address == PORT_TONE) begin
          if (tone_high) tone_div[15:8] = w.write_data;
          else tone_div[7:0] = w.write_data;
          tone_high = ~tone_high;
          // tone starts once the high byte is in and gate plus data are on
          if (!tone_high && spk_ctrl[1:0] == 2'b11) begin
            r.speaker_event   = SPK_START;
            r.speaker_divisor = tone_div;
          end
        end else if (w.port_address == PORT_SPEAKER) begin
          spk_ctrl = w.write_data;
          if (w.write_data[1:0] != 2'b11) r.speaker_event = SPK_STOP;
        end else if (w.port_address == PORT_GAME) begin
          x_count = x_load;
          y_count = y_load;
        end
      end
      OP_AXIS_UPDATE: begin
        if (w.axis_index == 2'd0) x_load = axis_to_load(w.axis_value);
        else if (w.axis_index == 2'd1) y_load = axis_to_load(w.axis_value);
      end
      OP_BUTTON_PRESS: begin
        if (w.button_index < 3'd2) gp_bits[w.button_index + 4] = 1'b0;
      end
      OP_BUTTON_RELEASE: begin
        if (w.button_index < 3'd2) gp_bits[w.button_index + 4] = 1'b1;
      end
      OP_FRAME_MARK: status_reg = status_reg | STATUS_FRAME;
      default: ;
    endcase
    r.axes_timing = 2'(x_count != 0) + 2'(y_count != 0);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: everything is sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : port_monitor
    gpt_item_t   w;
    gpt_result_t got;
    gpt_result_t want;
    gpt_result_t calc;
    pin_note_t   note;
    if (rst) begin
      reset_port_model();
    end else begin
      // result side first; latency keeps this edge's input word out of the way
      if (m_tvalid && m_tready) begin
        got.read_data       = m_tdata[7:0];
        got.speaker_divisor = m_tdata[23:8];
        got.axes_timing     = m_tdata[25:24];
        got.speaker_event   = m_tuser;
        if (port_result_q.size() == 0) begin
          $error("result word with nothing expected: tdata %h tuser %h", m_tdata, m_tuser);
          errors++;
        end else begin
          want = port_result_q.pop_front();
          if (got.read_data != want.read_data) begin
            $error("read_data expected %h got %h", want.read_data, got.read_data);
            errors++;
          end
          if (got.speaker_event != want.speaker_event) begin
            $error("speaker_event expected %0d got %0d", want.speaker_event,
                   got.speaker_event);
            errors++;
          end
          if (got.speaker_divisor != want.speaker_divisor) begin
            $error("speaker_divisor expected %h got %h", want.speaker_divisor,
                   got.speaker_divisor);
            errors++;
          end
          if (got.axes_timing != want.axes_timing) begin
            $error("axes_timing expected %0d got %0d", want.axes_timing, got.axes_timing);
            errors++;
          end
        end
      end
      if (cfg_wr_en) joy_present = cfg_wr_data;
      if (s_tvalid && s_tready) begin
        w.operation    = s_tuser;
        w.port_address = s_tdata[15:0];
        w.write_data   = s_tdata[23:16];
        w.axis_index   = s_tdata[25:24];
        w.axis_value   = s_tdata[33:26];
        w.button_index = s_tdata[36:34];
        calc = apply_port_event(w);
        note.pinned = 1'b0;
        note.want   = '0;
        if (pin_q.size() != 0) note = pin_q.pop_front();
        port_result_q.push_back(note.pinned ? note.want : calc);
      end
    end
  end

  // watchdog: ends the run after too many cycles with no word moving
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** pc_gameport_timer_ports_unit: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // result side: random stalls plus an optional long hold-off
  // ---------------------------------------------------------------------------
  int recv_stall_pct = 0;
  int send_idle_pct  = 0;
  int hold_left      = 0;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // input side; called at a falling edge, returns at the falling edge
  // after the word was taken
  // ---------------------------------------------------------------------------
  task automatic send_word(input gpt_item_t w, input logic pinned, input gpt_result_t want);
    pin_note_t note;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tdata     = {3'b000, w.button_index, w.axis_value, w.axis_index, w.write_data,
                   w.port_address};
    s_tuser     = w.operation;
    s_tvalid    = 1'b1;
    note.pinned = pinned;
    note.want   = want;
    pin_q.push_back(note);
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // drop valid and wait for every outstanding result word
  task automatic drain_results();
    s_tvalid = 1'b0;
    while (port_result_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_joy_present(input logic value);
    drain_results();
    cfg_wr_data = value;
    cfg_wr_en   = 1'b1;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  // random word, weighted toward the decoded ports so the counters and the
  // tone divisor sequencing actually get exercised
  function automatic gpt_item_t random_word();
    gpt_item_t w;
    int        pick;
    int        port_pick;
    pick      = $urandom_range(99);
    port_pick = $urandom_range(99);
    w.write_data   = 8'($urandom);
    w.axis_index   = 2'($urandom_range(3));
    w.axis_value   = 8'($urandom);
    w.button_index = 3'($urandom_range(7));
    w.port_address = 16'($urandom);
    if (pick < 45) begin
      w.operation = OP_PORT_READ;
      if (port_pick < 55) w.port_address = PORT_GAME;
      else if (port_pick < 75) w.port_address = PORT_STATUS;
      else if (port_pick < 88) w.port_address = PORT_SPEAKER;
    end else if (pick < 70) begin
      w.operation = OP_PORT_WRITE;
      if (port_pick < 12) w.port_address = PORT_GAME;
      else if (port_pick < 52) w.port_address = PORT_TONE;
      else if (port_pick < 80) begin
        w.port_address = PORT_SPEAKER;
        // half the time turn the tone gate on so starts can happen
        if ($urandom_range(1)) w.write_data[1:0] = 2'b11;
      end else if (port_pick < 86) w.port_address = PORT_TIMER_MODE;
    end else if (pick < 80) begin
      w.operation = OP_AXIS_UPDATE;
    end else if (pick < 87) begin
      w.operation = OP_BUTTON_PRESS;
    end else if (pick < 94) begin
      w.operation = OP_BUTTON_RELEASE;
    end else if (pick < 98) begin
      w.operation = OP_FRAME_MARK;
    end else begin
      w.operation = $urandom_range(1) ? OP_RESERVED_LO : OP_RESERVED_HI;
    end
    return w;
  endfunction

  task automatic run_phase(input int idle_pct, input int stall_pct, input int words);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (words) send_word(random_word(), 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    gpt_item_t w;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed words, no idling
    for (int i = 0; i < DIRECTED_WORDS; i++) begin
      w.operation    = directed_rows[i].op;
      w.port_address = directed_rows[i].port;
      w.write_data   = directed_rows[i].wdata;
      w.axis_index   = directed_rows[i].axis;
      w.axis_value   = directed_rows[i].pos;
      w.button_index = directed_rows[i].button;
      send_word(w, directed_rows[i].pinned, directed_rows[i].want);
    end

    // random phases, the joystick flag flipped between them
    run_phase(0, 0, PHASE_WORDS);
    write_joy_present(1'b0);
    run_phase(87, 0, PHASE_WORDS);
    write_joy_present(1'b1);
    run_phase(0, 87, PHASE_WORDS);
    write_joy_present(1'b0);
    run_phase(16, 16, PHASE_WORDS);
    write_joy_present(1'b1);
    // long receiver hold-off while words keep coming: pipeline fills, s_tready drops
    hold_left = HOLD_OFF_LEN;
    run_phase(0, 0, PHASE_WORDS);

    drain_results();
    repeat (8) @(posedge clk);
    if (errors == 0 && port_result_q.size() == 0) begin
      $display("** pc_gameport_timer_ports_unit: PASSED **");
    end else begin
      $display("** pc_gameport_timer_ports_unit: FAILED **");
    end
    $finish;
  end

endmodule
